>>> rtl/tssb_pkg.sv
// Shared constants for the texture shade and specular blend block.
package tssb_pkg;

   localparam int unsigned DEFAULT_TEXEL_DEPTH = 65536;

   localparam int unsigned INDEX_W  = 16;
   localparam int unsigned OFFSET_W = 15;
   localparam int unsigned TEXEL_W  = 24;
   localparam int unsigned SHADE_W  = 8;
   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned NUM_CHAN = 3;
   localparam int unsigned PROD_W   = 2 * CHAN_W;

   // request operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // register indexes on the csr port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_SPECULAR    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROTATION_OFFSET = 1'b1;

   localparam logic       USE_SPECULAR_RESET    = 1'b1;
   localparam logic [OFFSET_W-1:0] ROTATION_OFFSET_RESET = '0;

endpackage

>>> rtl/tssb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
module tssb_ram #(
   parameter int unsigned WIDTH = tssb_pkg::TEXEL_W,
   parameter int unsigned DEPTH = tssb_pkg::DEFAULT_TEXEL_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/texture_shade_specular_blend.sv
// Top level: texel stores, address wrap pipeline and per-channel shade blend.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------
//   req     | in        | req_valid/req_ready   | operation, texel_index, color_texel,
//           |           |                       | spec_texel, diffuse_shade,
//           |           |                       | specular_shade
//   rsp     | out       | rsp_valid/rsp_ready   | pixel (one beat per pixel request)
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// One request beat is taken every cycle while the result channel drains. A pixel beat
// passes through the seven-stage pipeline: address add, reciprocal multiply and remainder
// stages and a correction stage for the wrap at the store depth, the store read, the
// channel multipliers and the final add. When a result beat waits and rsp_ready is low,
// every stage holds, including the store read register; nothing is dropped or repeated.
// Synchronous reset clears the stage valid bits and sets use_specular to 1 and
// rotation_offset to 0; the texel stores are not cleared. csr_ready is always high.
module texture_shade_specular_blend #(
   parameter int unsigned TEXEL_DEPTH = tssb_pkg::DEFAULT_TEXEL_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic [tssb_pkg::INDEX_W-1:0]        req_texel_index,
   input  logic [tssb_pkg::TEXEL_W-1:0]        req_color_texel,
   input  logic [tssb_pkg::TEXEL_W-1:0]        req_spec_texel,
   input  logic [tssb_pkg::SHADE_W-1:0]        req_diffuse_shade,
   input  logic [tssb_pkg::SHADE_W-1:0]        req_specular_shade,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tssb_pkg::TEXEL_W-1:0]        rsp_pixel,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tssb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tssb_pkg::OFFSET_W-1:0]       csr_data
);

   // Address width math. X_W holds index plus offset; the wrap is x mod TEXEL_DEPTH,
   // done as q = (x * RECIP) >> X_W, r = x - q * TEXEL_DEPTH, then one conditional
   // subtract. q undershoots by at most one, so r stays below twice the depth.
   localparam int unsigned AW      = $clog2(TEXEL_DEPTH);
   localparam int unsigned X_W     = tssb_pkg::INDEX_W + 1;
   localparam int unsigned RECIP   = (1 << X_W) / TEXEL_DEPTH;
   localparam int unsigned RECIP_W = X_W;
   localparam int unsigned DW      = $clog2(TEXEL_DEPTH + 1);
   localparam int unsigned CMP_W   = (DW > X_W) ? DW : X_W;

   localparam logic [RECIP_W-1:0] RECIP_C     = RECIP_W'(RECIP);
   localparam logic [DW-1:0]      DEPTH_C     = DW'(TEXEL_DEPTH);
   localparam logic [CMP_W-1:0]   DEPTH_CMP   = CMP_W'(TEXEL_DEPTH);
   localparam logic [CMP_W:0]     DEPTH_TWICE = (CMP_W + 1)'(2 * TEXEL_DEPTH);

   localparam int unsigned TW = tssb_pkg::TEXEL_W;
   localparam int unsigned SW = tssb_pkg::SHADE_W;
   localparam int unsigned CW = tssb_pkg::CHAN_W;
   localparam int unsigned PW = tssb_pkg::PROD_W;
   localparam int unsigned NC = tssb_pkg::NUM_CHAN;

   // ---------------------------------------------------------------- control
   logic advance;

   // Whole pipeline moves together; hold everything while a result beat is stuck.
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- csr
   logic                          use_specular_ff;
   logic [tssb_pkg::OFFSET_W-1:0] rotation_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_specular_ff    <= tssb_pkg::USE_SPECULAR_RESET;
         rotation_offset_ff <= tssb_pkg::ROTATION_OFFSET_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            tssb_pkg::CSR_USE_SPECULAR:    use_specular_ff    <= csr_data[0];
            tssb_pkg::CSR_ROTATION_OFFSET: rotation_offset_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, rsp_valid_ff;
   logic op1_ff, op2_ff, op3_ff, op4_ff, op5_ff, op6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         // loads end here silently; only pixels produce a beat
         rsp_valid_ff <= v6_ff && (op6_ff == tssb_pkg::OP_PIXEL);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------- stage 1: add offset
   logic [X_W-1:0] s1_x_in, s1_x_ff;
   logic [TW-1:0]  s1_color_ff, s1_spec_ff;
   logic [SW-1:0]  s1_ds_ff, s1_ss_ff;

   // Loads address the store directly; pixels add the spin offset.
   assign s1_x_in = X_W'(req_texel_index)
                  + ((req_operation == tssb_pkg::OP_PIXEL) ? X_W'(rotation_offset_ff) : '0);

   always_ff @(posedge clock) begin
      if (advance) begin
         op1_ff      <= req_operation;
         s1_x_ff     <= s1_x_in;
         s1_color_ff <= req_color_texel;
         s1_spec_ff  <= req_spec_texel;
         s1_ds_ff    <= req_diffuse_shade;
         s1_ss_ff    <= req_specular_shade;
      end
   end

   // ---------------------------------------------------------------- stage 2: reciprocal
   logic [X_W+RECIP_W-1:0] s2_prod_in, s2_prod_ff;
   logic [X_W-1:0]         s2_x_ff;
   logic [TW-1:0]          s2_color_ff, s2_spec_ff;
   logic [SW-1:0]          s2_ds_ff, s2_ss_ff;

   assign s2_prod_in = (X_W + RECIP_W)'(s1_x_ff) * (X_W + RECIP_W)'(RECIP_C);

   always_ff @(posedge clock) begin
      if (advance) begin
         op2_ff      <= op1_ff;
         s2_prod_ff  <= s2_prod_in;
         s2_x_ff     <= s1_x_ff;
         s2_color_ff <= s1_color_ff;
         s2_spec_ff  <= s1_spec_ff;
         s2_ds_ff    <= s1_ds_ff;
         s2_ss_ff    <= s1_ss_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3: remainder
   logic [X_W-1:0]    s2_quot;
   logic [X_W+DW-1:0] s3_qd;
   logic [X_W-1:0]    s3_r_in, s3_r_ff;
   logic [TW-1:0]     s3_color_ff, s3_spec_ff;
   logic [SW-1:0]     s3_ds_ff, s3_ss_ff;

   assign s2_quot = s2_prod_ff[X_W+RECIP_W-1:RECIP_W];
   assign s3_qd   = (X_W + DW)'(s2_quot) * (X_W + DW)'(DEPTH_C);
   // quotient never overshoots, so the remainder fits in X_W bits
   assign s3_r_in = s2_x_ff - s3_qd[X_W-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         op3_ff      <= op2_ff;
         s3_r_ff     <= s3_r_in;
         s3_color_ff <= s2_color_ff;
         s3_spec_ff  <= s2_spec_ff;
         s3_ds_ff    <= s2_ds_ff;
         s3_ss_ff    <= s2_ss_ff;
      end
   end

   // ---------------------------------------------------------------- stage 4: correction
   logic [CMP_W-1:0] s3_r_cmp, s4_addr_wide;
   logic [AW-1:0]    s4_addr_ff;
   logic [TW-1:0]    s4_color_ff, s4_spec_ff;
   logic [SW-1:0]    s4_ds_ff, s4_ss_ff;

   assign s3_r_cmp     = CMP_W'(s3_r_ff);
   assign s4_addr_wide = (s3_r_cmp >= DEPTH_CMP) ? (s3_r_cmp - DEPTH_CMP) : s3_r_cmp;

   always_ff @(posedge clock) begin
      if (advance) begin
         op4_ff      <= op3_ff;
         s4_addr_ff  <= s4_addr_wide[AW-1:0];
         s4_color_ff <= s3_color_ff;
         s4_spec_ff  <= s3_spec_ff;
         s4_ds_ff    <= s3_ds_ff;
         s4_ss_ff    <= s3_ss_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5: texel stores
   logic          ram_we, ram_re;
   logic [TW-1:0] s5_color_rd, s5_spec_rd;
   logic [SW-1:0] s5_ds_ff, s5_ss_ff;

   // Write or read exactly once, on the move from stage 4 into stage 5.
   assign ram_we = advance && v4_ff && (op4_ff == tssb_pkg::OP_LOAD);
   assign ram_re = advance && v4_ff && (op4_ff == tssb_pkg::OP_PIXEL);

   tssb_ram #(.WIDTH(TW), .DEPTH(TEXEL_DEPTH)) u_color_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s4_addr_ff),
      .wr_data (s4_color_ff),
      .rd_en   (ram_re),
      .rd_addr (s4_addr_ff),
      .rd_data (s5_color_rd)
   );

   tssb_ram #(.WIDTH(TW), .DEPTH(TEXEL_DEPTH)) u_spec_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s4_addr_ff),
      .wr_data (s4_spec_ff),
      .rd_en   (ram_re),
      .rd_addr (s4_addr_ff),
      .rd_data (s5_spec_rd)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         op5_ff   <= op4_ff;
         s5_ds_ff <= s4_ds_ff;
         s5_ss_ff <= s4_ss_ff;
      end
   end

   // ---------------------------------------------------------------- stage 6: multiply
   logic [PW-1:0] s6_cprod_in [NC];
   logic [PW-1:0] s6_sprod_in [NC];
   logic [PW-1:0] s6_cprod_ff [NC];
   logic [PW-1:0] s6_sprod_ff [NC];

   always_comb begin
      for (int b = 0; b < NC; b++) begin
         s6_cprod_in[b] = PW'(s5_color_rd[CW*b +: CW]) * PW'(s5_ds_ff);
         // drop the specular term when it is disabled
         s6_sprod_in[b] = use_specular_ff ? (PW'(s5_spec_rd[CW*b +: CW]) * PW'(s5_ss_ff))
                                          : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op6_ff <= op5_ff;
         for (int b = 0; b < NC; b++) begin
            s6_cprod_ff[b] <= s6_cprod_in[b];
            s6_sprod_ff[b] <= s6_sprod_in[b];
         end
      end
   end

   // ---------------------------------------------------------------- stage 7: blend, output
   logic [PW:0]   s7_sum [NC];
   logic [TW-1:0] s7_pixel_in, rsp_pixel_ff;

   // Saturate on a carry out of 16 bits, keep the high byte; byte 0 lands on top.
   always_comb begin
      s7_pixel_in = '0;
      for (int b = 0; b < NC; b++) begin
         s7_sum[b] = (PW + 1)'(s6_cprod_ff[b]) + (PW + 1)'(s6_sprod_ff[b]);
         s7_pixel_in[CW*(NC-1-b) +: CW] = s7_sum[b][PW] ? {CW{1'b1}} : s7_sum[b][PW-1:CW];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pixel_ff <= s7_pixel_in;
      end
   end

   assign rsp_pixel = rsp_pixel_ff;

   // ---------------------------------------------------------------- assertions
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff}))
      else $error("pipeline valid bits moved during a stall");

   a_store_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("store written and read in the same cycle");

   a_wrap_bound: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> ((CMP_W + 1)'(s3_r_cmp) < DEPTH_TWICE))
      else $error("remainder out of range for a single correction");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v6_ff && (op6_ff == tssb_pkg::OP_PIXEL) && advance))
      else $error("result beat without a pixel request behind it");

endmodule
